// File: rtl/slme_pkg.sv
// slme_pkg: shared types and codes of the sorted list merge engine
// no dependencies; used by the interfaces, the cell, the chain and the top level
package slme_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_MERGE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_A      = 2'd0,
		SEL_B      = 2'd1,
		SEL_MERGED = 2'd2,
		SEL_NONE   = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	// per-cycle control shared by every cell of one chain
	typedef struct packed {
		logic ins;
		logic shl;
		logic wr;
	} cell_ctl_t;

endpackage

// File: rtl/slme_in_if.sv
// slme_in_if: command channel of the sorted list merge engine
// depends on slme_pkg
interface slme_in_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic [1:0]           list_select;
	slme_pkg::data_t      value;

	modport source (output valid, command, list_select, value, input ready);
	modport sink (input valid, command, list_select, value, output ready);
endinterface

// File: rtl/slme_out_if.sv
// slme_out_if: result channel of the sorted list merge engine
// depends on slme_pkg
interface slme_out_if;
	logic                 valid;
	logic                 ready;
	slme_pkg::data_t      value_out;
	logic [1:0]           status;
	logic                 last;

	modport source (output valid, value_out, status, last, input ready);
	modport sink (input valid, value_out, status, last, output ready);
endinterface

// File: rtl/sorted_list_merge_engine_core.sv
// sorted_list_merge_engine_core: two sorted lists and a merged list in cell chains
// depends on slme_pkg, slme_in_if, slme_out_if, slme_chain
//
// channel  | dir | fields
// request  | in  | command, list_select, value
// result   | out | value_out, status, last
//
// insert, clear, merge-clear: result register loaded from the execute state once the result slot is free
// read out: a decode step, then LIST_DEPTH rotations (2*LIST_DEPTH for merged), one entry per cycle while not stalled
// merge: moves entries in the order set by the head compare of the chains, list A on a tie
// reset empties all lists through their counts; cell contents are not cleared
// a stalled result holds read out rotation while entries remain, and the final merge result; merge moves go on
// a new command is taken in idle, after the last result of the previous one is registered and rotations are done
module sorted_list_merge_engine_core #(
	parameter int LIST_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	slme_in_if.sink    request,
	slme_out_if.source result
);
	import slme_pkg::*;

	localparam int MD  = 2 * LIST_DEPTH;
	localparam int CW  = $clog2(LIST_DEPTH + 1);
	localparam int MCW = $clog2(MD + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_READ  = 4'b0100,
		S_MERGE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	cmd_t cmd_q;
	sel_t sel_q;
	data_t val_q;
	logic [CW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
	logic [MCW-1:0] m_cnt_q, m_cnt_d, k_q, k_d, n_q, n_d, len_q, len_d;
	cell_ctl_t a_ctl, b_ctl, m_ctl;
	data_t a_head, b_head, m_head, m_din, sel_head;
	logic take_a, slot_free, emit, o_last;
	data_t o_val;
	status_t o_st;
	logic out_v_q;
	data_t out_val_q;
	status_t out_st_q;
	logic out_last_q;

	slme_chain #(.DEPTH(LIST_DEPTH), .CW(CW)) u_a (
		.clk(clk), .ctl(a_ctl), .cnt(a_cnt_q), .din(val_q), .head(a_head));
	slme_chain #(.DEPTH(LIST_DEPTH), .CW(CW)) u_b (
		.clk(clk), .ctl(b_ctl), .cnt(b_cnt_q), .din(val_q), .head(b_head));
	slme_chain #(.DEPTH(MD), .CW(MCW)) u_m (
		.clk(clk), .ctl(m_ctl), .cnt(m_cnt_q), .din(m_din), .head(m_head));

	assign slot_free = !out_v_q || result.ready;
	assign take_a = (b_cnt_q == '0) || ((a_cnt_q != '0) && (a_head <= b_head));
	assign m_din = take_a ? a_head : b_head;
	assign request.ready = (state_q == S_IDLE);

	always_comb begin
		unique case (sel_q)
			SEL_A:   sel_head = a_head;
			SEL_B:   sel_head = b_head;
			default: sel_head = m_head;
		endcase
	end

	always_comb begin
		state_d = state_q;
		a_cnt_d = a_cnt_q;
		b_cnt_d = b_cnt_q;
		m_cnt_d = m_cnt_q;
		k_d = k_q;
		n_d = n_q;
		len_d = len_q;
		a_ctl = '0;
		b_ctl = '0;
		m_ctl = '0;
		emit = 1'b0;
		o_val = '0;
		o_st = ST_OK;
		o_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (request.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd_q == CMD_MERGE) begin
					if (m_cnt_q != '0) begin
						if (slot_free) begin
							m_cnt_d = '0;
							emit = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_MERGE;
					end
				end else if (slot_free) begin
					emit = 1'b1;
					state_d = S_IDLE;
					case (cmd_q)
						CMD_INSERT: begin
							if (sel_q == SEL_A) begin
								if (a_cnt_q == CW'(LIST_DEPTH)) o_st = ST_FULL;
								else begin
									a_ctl.ins = 1'b1;
									a_cnt_d = a_cnt_q + 1'b1;
								end
							end else if (sel_q == SEL_B) begin
								if (b_cnt_q == CW'(LIST_DEPTH)) o_st = ST_FULL;
								else begin
									b_ctl.ins = 1'b1;
									b_cnt_d = b_cnt_q + 1'b1;
								end
							end else o_st = ST_BAD;
						end
						CMD_CLEAR: begin
							if (sel_q == SEL_A) begin
								o_st = (a_cnt_q == '0) ? ST_EMPTY : ST_OK;
								a_cnt_d = '0;
							end else if (sel_q == SEL_B) begin
								o_st = (b_cnt_q == '0) ? ST_EMPTY : ST_OK;
								b_cnt_d = '0;
							end else o_st = ST_BAD;
						end
						default: begin
							if (sel_q == SEL_NONE) o_st = ST_BAD;
							else begin
								if (sel_q == SEL_A) n_d = {{(MCW-CW){1'b0}}, a_cnt_q};
								else if (sel_q == SEL_B) n_d = {{(MCW-CW){1'b0}}, b_cnt_q};
								else n_d = m_cnt_q;
								len_d = (sel_q == SEL_MERGED) ? MCW'(MD) : MCW'(LIST_DEPTH);
								if (n_d == '0) o_st = ST_EMPTY;
								else begin
									emit = 1'b0;
									k_d = '0;
									state_d = S_READ;
								end
							end
						end
					endcase
				end
			end
			S_READ: begin
				if ((k_q >= n_q) || slot_free) begin
					case (sel_q)
						SEL_A:   a_ctl.shl = 1'b1;
						SEL_B:   b_ctl.shl = 1'b1;
						default: m_ctl.shl = 1'b1;
					endcase
					if (k_q < n_q) begin
						emit = 1'b1;
						o_val = sel_head;
						o_last = (k_q == n_q - 1'b1);
					end
					k_d = k_q + 1'b1;
					if (k_q == len_q - 1'b1) state_d = S_IDLE;
				end
			end
			default: begin
				if ((a_cnt_q != '0) || (b_cnt_q != '0)) begin
					m_ctl.wr = 1'b1;
					m_cnt_d = m_cnt_q + 1'b1;
					if (take_a) begin
						a_ctl.shl = 1'b1;
						a_cnt_d = a_cnt_q - 1'b1;
					end else begin
						b_ctl.shl = 1'b1;
						b_cnt_d = b_cnt_q - 1'b1;
					end
				end else if (slot_free) begin
					emit = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			m_cnt_q <= '0;
			k_q <= '0;
			n_q <= '0;
			len_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			a_cnt_q <= a_cnt_d;
			b_cnt_q <= b_cnt_d;
			m_cnt_q <= m_cnt_d;
			k_q <= k_d;
			n_q <= n_d;
			len_q <= len_d;
			if (slot_free) out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			cmd_q <= cmd_t'(request.command);
			sel_q <= sel_t'(request.list_select);
			val_q <= request.value;
		end
		if (emit) begin
			out_val_q <= o_val;
			out_st_q <= o_st;
			out_last_q <= o_last;
		end
	end

	assign result.valid = out_v_q;
	assign result.value_out = out_val_q;
	assign result.status = out_st_q;
	assign result.last = out_last_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		(a_cnt_q <= CW'(LIST_DEPTH)) && (b_cnt_q <= CW'(LIST_DEPTH)))
		else $error("list count above depth");
	m_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_cnt_q <= MCW'(MD))
		else $error("merged count above depth");
	read_holds_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> ($stable(a_cnt_q) && $stable(b_cnt_q) && $stable(m_cnt_q)))
		else $error("count changed during read out");
	merge_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE && state_d == S_IDLE) |-> (a_cnt_q == '0 && b_cnt_q == '0))
		else $error("merge ended with entries left");
endmodule

// File: rtl/slme_cell.sv
// slme_cell: one list entry; sorted insert, rotate toward the head, append
// depends on slme_pkg
module slme_cell (
	input  logic                clk,
	input  slme_pkg::cell_ctl_t ctl,
	input  logic                valid,
	input  logic                tail,
	input  slme_pkg::data_t     din,
	input  slme_pkg::data_t     left_q,
	input  logic                left_gt,
	input  slme_pkg::data_t     right_q,
	output slme_pkg::data_t     q,
	output logic                gt
);
	import slme_pkg::*;

	assign gt = valid && (q > din);

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			q <= right_q;
		end else if (ctl.ins && (gt || tail)) begin
			q <= left_gt ? left_q : din;
		end else if (ctl.wr && tail) begin
			q <= din;
		end
	end
endmodule

// File: rtl/slme_chain.sv
// slme_chain: row of slme_cell entries forming one ascending list
// depends on slme_pkg and slme_cell
module slme_chain #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic                clk,
	input  slme_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       cnt,
	input  slme_pkg::data_t     din,
	output slme_pkg::data_t     head
);
	import slme_pkg::*;

	data_t q  [DEPTH];
	logic  gt [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t lq;
		logic  lg;
		if (i == 0) begin : g_first
			assign lq = din;
			assign lg = 1'b0;
		end else begin : g_rest
			assign lq = q[i-1];
			assign lg = gt[i-1];
		end
		slme_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.valid   (cnt > CW'(i)),
			.tail    (cnt == CW'(i)),
			.din     (din),
			.left_q  (lq),
			.left_gt (lg),
			.right_q (q[(i + 1) % DEPTH]),
			.q       (q[i]),
			.gt      (gt[i])
		);
	end

	assign head = q[0];
endmodule

// File: tb/sv/sorted_list_merge_engine_core_test.sv
// sorted_list_merge_engine_core_test: drives commands into the engine and checks every result
// against an in-bench list predictor or the directed table's status; directed table first, then random traffic
// depends on slme_pkg, slme_in_if, slme_out_if and sorted_list_merge_engine_core
`timescale 1ns / 1ps

module sorted_list_merge_engine_core_test;
	import slme_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int MERGED_DEPTH = 2 * LIST_DEPTH;
	localparam int RANDOM_ITEMS = 250;

	typedef struct {
		data_t   value_out;
		status_t status;
		logic    last;
	} list_result_t;

	typedef struct {
		cmd_t    command;
		sel_t    list_select;
		data_t   value;
		bit      typed;
		status_t status;
	} table_row_t;

	logic clk;
	logic arst_n;
	slme_in_if request ();
	slme_out_if result ();

	sorted_list_merge_engine_core #(.LIST_DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.result(result)
	);

	data_t list_a[LIST_DEPTH];
	data_t list_b[LIST_DEPTH];
	data_t merged[MERGED_DEPTH];
	int count_a, count_b, count_merged;
	list_result_t pending_results[$];
	int mismatches;
	int send_idle_pct, stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic void push_result(data_t v, status_t st, logic lst);
		list_result_t r;
		r.value_out = v;
		r.status = st;
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	function automatic status_t insert_sorted(ref data_t cells[LIST_DEPTH], ref int n,
			input data_t v);
		int pos;
		if (n >= LIST_DEPTH)
			return ST_FULL;
		pos = n;
		while (pos > 0 && cells[pos-1] > v) begin
			cells[pos] = cells[pos-1];
			pos--;
		end
		cells[pos] = v;
		n++;
		return ST_OK;
	endfunction

	function automatic void merge_lists();
		int i, j, k;
		i = 0;
		j = 0;
		k = 0;
		while (i < count_a || j < count_b) begin
			if (j >= count_b || (i < count_a && list_a[i] <= list_b[j]))
				merged[k++] = list_a[i++];
			else
				merged[k++] = list_b[j++];
		end
		count_merged = k;
		count_a = 0;
		count_b = 0;
	endfunction

	function automatic void predict_command(cmd_t c, sel_t s, data_t v);
		int n;
		case (c)
			CMD_INSERT: begin
				if (s == SEL_A)
					push_result('0, insert_sorted(list_a, count_a, v), 1'b1);
				else if (s == SEL_B)
					push_result('0, insert_sorted(list_b, count_b, v), 1'b1);
				else
					push_result('0, ST_BAD, 1'b1);
			end
			CMD_READ: begin
				if (s == SEL_NONE) begin
					push_result('0, ST_BAD, 1'b1);
				end else begin
					n = (s == SEL_A) ? count_a : (s == SEL_B) ? count_b : count_merged;
					if (n == 0)
						push_result('0, ST_EMPTY, 1'b1);
					for (int k = 0; k < n; k++)
						push_result((s == SEL_A) ? list_a[k] : (s == SEL_B) ? list_b[k] :
							merged[k], ST_OK, k == n - 1);
				end
			end
			CMD_CLEAR: begin
				if (s == SEL_A) begin
					push_result('0, count_a == 0 ? ST_EMPTY : ST_OK, 1'b1);
					count_a = 0;
				end else if (s == SEL_B) begin
					push_result('0, count_b == 0 ? ST_EMPTY : ST_OK, 1'b1);
					count_b = 0;
				end else begin
					push_result('0, ST_BAD, 1'b1);
				end
			end
			default: begin
				if (count_merged == 0)
					merge_lists();
				else
					count_merged = 0;
				push_result('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	task automatic send_command(cmd_t c, sel_t s, data_t v, bit typed, status_t st);
		while ($urandom_range(99) < send_idle_pct) begin
			request.valid = 1'b0;
			@(negedge clk);
		end
		request.valid = 1'b1;
		request.command = c;
		request.list_select = s;
		request.value = v;
		do @(posedge clk); while (!request.ready);
		if (typed) begin
			predict_command(c, s, v);
			void'(pending_results.pop_back());
			push_result('0, st, 1'b1);
		end else begin
			predict_command(c, s, v);
		end
		@(negedge clk);
	endtask

	always @(negedge clk)
		result.ready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: value %0d status %0d last %0b",
						result.value_out, result.status, result.last);
			end else begin
				want = pending_results.pop_front();
				if (result.value_out !== want.value_out || result.status !== want.status ||
						result.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							want.value_out, want.status, want.last,
							result.value_out, result.status, result.last);
				end
			end
		end
	end

	initial begin
		table_row_t rows[$];
		int total, r, pick;
		cmd_t c;
		sel_t s;
		rows = '{
			'{CMD_READ, SEL_A, 0, 1, ST_EMPTY},
			'{CMD_READ, SEL_B, 0, 1, ST_EMPTY},
			'{CMD_READ, SEL_MERGED, 0, 1, ST_EMPTY},
			'{CMD_READ, SEL_NONE, 0, 1, ST_BAD},
			'{CMD_INSERT, SEL_MERGED, 7, 1, ST_BAD},
			'{CMD_INSERT, SEL_NONE, 7, 1, ST_BAD},
			'{CMD_CLEAR, SEL_A, 0, 1, ST_EMPTY},
			'{CMD_CLEAR, SEL_MERGED, 0, 1, ST_BAD},
			'{CMD_CLEAR, SEL_NONE, 0, 1, ST_BAD},
			'{CMD_INSERT, SEL_A, 32'sh7fffffff, 1, ST_OK},
			'{CMD_INSERT, SEL_A, 32'sh80000000, 1, ST_OK},
			'{CMD_INSERT, SEL_A, 0, 1, ST_OK},
			'{CMD_INSERT, SEL_A, -1, 1, ST_OK},
			'{CMD_INSERT, SEL_A, -1, 1, ST_OK},
			'{CMD_INSERT, SEL_B, 5, 1, ST_OK},
			'{CMD_INSERT, SEL_B, -1, 1, ST_OK},
			'{CMD_READ, SEL_A, 0, 0, ST_OK},
			'{CMD_READ, SEL_B, 0, 0, ST_OK},
			'{CMD_MERGE, SEL_NONE, 0, 1, ST_OK},
			'{CMD_READ, SEL_MERGED, 0, 0, ST_OK},
			'{CMD_READ, SEL_A, 0, 1, ST_EMPTY},
			'{CMD_MERGE, SEL_A, 0, 1, ST_OK},
			'{CMD_READ, SEL_MERGED, 0, 1, ST_EMPTY},
			'{CMD_MERGE, SEL_B, 0, 1, ST_OK},
			'{CMD_READ, SEL_MERGED, 0, 1, ST_EMPTY}
		};
		total = rows.size() + RANDOM_ITEMS;
		mismatches = 0;
		count_a = 0;
		count_b = 0;
		count_merged = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		request.valid = 1'b0;
		request.command = CMD_INSERT;
		request.list_select = SEL_A;
		request.value = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < total; i++) begin
			case (i * 4 / total)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 83; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 83; end
				default: begin send_idle_pct = 28; stall_pct = 28; end
			endcase
			if (i < rows.size()) begin
				send_command(rows[i].command, rows[i].list_select, rows[i].value,
					rows[i].typed, rows[i].status);
			end else begin
				pick = $urandom_range(99);
				r = $urandom_range(99);
				if (pick < 60) begin
					c = CMD_INSERT;
					s = r < 47 ? SEL_A : r < 94 ? SEL_B : r < 97 ? SEL_MERGED : SEL_NONE;
				end else if (pick < 80) begin
					c = CMD_READ;
					s = sel_t'($urandom_range(3));
				end else if (pick < 88) begin
					c = CMD_CLEAR;
					s = sel_t'($urandom_range(3));
				end else begin
					c = CMD_MERGE;
					s = sel_t'($urandom_range(3));
				end
				send_command(c, s, data_t'($urandom()), 1'b0, ST_OK);
			end
		end
		request.valid = 1'b0;
		fork
			wait (pending_results.size() == 0);
			repeat (200000) @(posedge clk);
		join_any
		disable fork;
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
